// ===== hw/rtl/wavhdr_pkg.sv =====
// wavhdr_pkg: shared types, codes and constants of the WAVE header parser.
// Used by wavhdr_calc, wavhdr_parse and wav_header_duration_parser.
// No dependencies.
package wavhdr_pkg;

  // Result status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadTag   = 3'd1;
  localparam logic [2:0] StNoData   = 3'd2;
  localparam logic [2:0] StBadFmt   = 3'd3;
  localparam logic [2:0] StOverflow = 3'd4;

  // Chunk ids and tags, little-endian as they sit in the shift register
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6d66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [31:0] SizeOverflow = 32'h7FFF_FFF7;

  localparam int MinHead  = 44;
  localparam int MsPerS   = 1000;
  localparam int FmtMin   = 16;
  localparam int RiffEnd  = 3;
  localparam int WaveEnd  = 11;
  localparam int HdrBytes = 8;

  // fmt body byte offsets
  localparam int FmtOffChan = 2;
  localparam int FmtOffRate = 4;
  localparam int FmtOffBits = 14;

  localparam int OffW     = 5;
  localparam int DurW     = 41;
  localparam int DivW     = 60;
  localparam int MulW     = 32;
  localparam int MulSteps = 32;
  localparam int CntW     = 6;

  typedef enum logic [2:0] {
    PhTag,
    PhHdr,
    PhFmt,
    PhSkip,
    PhWait,
    PhCalc
  } phase_e;

  typedef enum logic [2:0] {
    CsIdle,
    CsMulFrame,
    CsMulDivisor,
    CsMulDividend,
    CsDivide,
    CsDone
  } calc_state_e;

  typedef struct packed {
    logic        start;
    logic [15:0] channels;
    logic [12:0] bytes_per;
    logic [30:0] rate;
    logic [30:0] size;
  } calc_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DurW-1:0] quotient;
  } calc_rsp_t;

  typedef struct packed {
    logic            valid;
    logic [2:0]      status;
    logic [DurW-1:0] duration;
  } result_t;

endpackage

// ===== hw/rtl/wav_header_duration_parser.sv =====
// wav_header_duration_parser: top level of the RIFF/WAVE header duration parser.
// Instantiates wavhdr_parse and wavhdr_calc; depends on wavhdr_pkg.
//
//   Channel  Dir  Handshake              Payload
//   in       in   in_valid_i/in_ready_o  byte_value_i[7:0], last_byte_i
//   out      out  out_valid_o/out_ready_i status_o[2:0], duration_ms_o[40:0]
//
// Cycles: one byte item per cycle while input is not stalled. The byte that completes the data chunk
//   header starts the serial arithmetic unit (three 32-step shift-add
//   multiplies, a 41-step restoring divide, a done state): input stalls
//   from that item until the unit is done, once per file.
// Reset: asynchronous, active low; parser returns to the tag check phase.
//   The final byte of each file also returns the parser to that state.
// Stalls: a result sits in a one-deep output register; input is taken while
//   it waits only if out_ready_i frees it in the same cycle.
module wav_header_duration_parser #(
  parameter int HEAD_LIMIT = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [40:0] duration_ms_o
);

  wavhdr_pkg::calc_req_t calc_req;
  wavhdr_pkg::calc_rsp_t calc_rsp;
  wavhdr_pkg::result_t   res;

  logic                        prs_busy;
  logic                        in_acc;
  logic                        out_valid_q, out_valid_d;
  logic [2:0]                  status_q;
  logic [wavhdr_pkg::DurW-1:0] dur_q;

  // Input waits while the arithmetic unit runs or while an unread result blocks the slot
  assign in_ready_o = !prs_busy && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  wavhdr_parse #(
    .HEAD_LIMIT(HEAD_LIMIT)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .byte_i     (byte_value_i),
    .last_i     (last_byte_i),
    .calc_rsp_i (calc_rsp),
    .calc_req_o (calc_req),
    .res_o      (res),
    .busy_o     (prs_busy)
  );

  wavhdr_calc u_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (calc_req),
    .rsp_o  (calc_rsp)
  );

  // Output register: load a new verdict, else drop a taken one
  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      dur_q    <= res.duration;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign duration_ms_o = dur_q;

  // Failures carry no duration
  a_fail_zero_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != wavhdr_pkg::StOk) |-> duration_ms_o == '0)
    else $error("failure result with nonzero duration");

  // Verdicts come only from an accepted byte or a finished division
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> in_acc || calc_rsp.done)
    else $error("verdict without a cause");

  // Never overwrite an unread result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !out_valid_q || out_ready_i)
    else $error("result register overwritten");

  // Input is held off for the whole division
  a_calc_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_rsp.busy |-> !in_ready_o)
    else $error("input taken during division");

endmodule

// ===== hw/rtl/wavhdr_calc.sv =====
// wavhdr_calc: bit-serial duration unit. Shift-add multiplies build the
// divisor and dividend, then a restoring divider yields one quotient bit per cycle.
// Depends on wavhdr_pkg.
module wavhdr_calc (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wavhdr_pkg::calc_req_t req_i,
  output wavhdr_pkg::calc_rsp_t rsp_o
);

  wavhdr_pkg::calc_state_e state_q, state_d;

  logic [wavhdr_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [wavhdr_pkg::MulW-1:0] mcand_q, mcand_d;
  logic [wavhdr_pkg::MulW-1:0] mplier_q, mplier_d;
  logic [wavhdr_pkg::DivW-1:0] acc_q, acc_d;
  logic [wavhdr_pkg::DivW-1:0] divisor_q, divisor_d;
  logic [wavhdr_pkg::DivW-1:0] rem_q, rem_d;
  logic [wavhdr_pkg::DurW-1:0] quot_q, quot_d;
  logic [30:0]                 size_q, size_d;
  logic [30:0]                 rate_q, rate_d;

  logic [wavhdr_pkg::DivW-1:0] acc_step;
  logic [wavhdr_pkg::DivW:0]   rem_sh;
  logic                        rem_ge;
  logic                        mul_last;
  logic                        div_last;

  // MSB-first shift-add step
  assign acc_step = {acc_q[wavhdr_pkg::DivW-2:0], 1'b0} +
                    (mplier_q[wavhdr_pkg::MulW-1] ?
                     {{(wavhdr_pkg::DivW-wavhdr_pkg::MulW){1'b0}}, mcand_q} :
                     {wavhdr_pkg::DivW{1'b0}});

  assign rem_sh   = {rem_q, quot_q[wavhdr_pkg::DurW-1]};
  assign rem_ge   = rem_sh >= {1'b0, divisor_q};
  assign mul_last = cnt_q == wavhdr_pkg::CntW'(wavhdr_pkg::MulSteps - 1);
  assign div_last = cnt_q == wavhdr_pkg::CntW'(wavhdr_pkg::DurW - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      wavhdr_pkg::CsIdle: begin
        if (req_i.start) state_d = wavhdr_pkg::CsMulFrame;
      end
      wavhdr_pkg::CsMulFrame: begin
        if (mul_last) state_d = wavhdr_pkg::CsMulDivisor;
      end
      wavhdr_pkg::CsMulDivisor: begin
        if (mul_last) state_d = wavhdr_pkg::CsMulDividend;
      end
      wavhdr_pkg::CsMulDividend: begin
        if (mul_last) state_d = wavhdr_pkg::CsDivide;
      end
      wavhdr_pkg::CsDivide: begin
        if (div_last) state_d = wavhdr_pkg::CsDone;
      end
      wavhdr_pkg::CsDone: state_d = wavhdr_pkg::CsIdle;
      default: state_d = wavhdr_pkg::CsIdle;
    endcase
  end

  always_comb begin
    cnt_d     = cnt_q;
    mcand_d   = mcand_q;
    mplier_d  = mplier_q;
    acc_d     = acc_q;
    divisor_d = divisor_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    size_d    = size_q;
    rate_d    = rate_q;
    case (state_q)
      wavhdr_pkg::CsIdle: begin
        if (req_i.start) begin
          mcand_d  = {16'b0, req_i.channels};
          mplier_d = {19'b0, req_i.bytes_per};
          size_d   = req_i.size;
          rate_d   = req_i.rate;
          acc_d    = '0;
          cnt_d    = '0;
        end
      end
      wavhdr_pkg::CsMulFrame, wavhdr_pkg::CsMulDivisor, wavhdr_pkg::CsMulDividend: begin
        acc_d    = acc_step;
        mplier_d = {mplier_q[wavhdr_pkg::MulW-2:0], 1'b0};
        cnt_d    = cnt_q + 1'b1;
        if (mul_last) begin
          cnt_d = '0;
          acc_d = '0;
          if (state_q == wavhdr_pkg::CsMulFrame) begin
            // frame bytes fit 29 bits
            mcand_d  = acc_step[wavhdr_pkg::MulW-1:0];
            mplier_d = {1'b0, rate_q};
          end else if (state_q == wavhdr_pkg::CsMulDivisor) begin
            divisor_d = acc_step;
            mcand_d   = {1'b0, size_q};
            mplier_d  = wavhdr_pkg::MulW'(wavhdr_pkg::MsPerS);
          end else begin
            quot_d = acc_step[wavhdr_pkg::DurW-1:0];
            rem_d  = '0;
          end
        end
      end
      wavhdr_pkg::CsDivide: begin
        rem_d  = rem_ge ? wavhdr_pkg::DivW'(rem_sh - {1'b0, divisor_q})
                        : rem_sh[wavhdr_pkg::DivW-1:0];
        quot_d = {quot_q[wavhdr_pkg::DurW-2:0], rem_ge};
        cnt_d  = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wavhdr_pkg::CsIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q   <= mcand_d;
    mplier_q  <= mplier_d;
    acc_q     <= acc_d;
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    quot_q    <= quot_d;
    size_q    <= size_d;
    rate_q    <= rate_d;
  end

  assign rsp_o.busy     = state_q != wavhdr_pkg::CsIdle;
  assign rsp_o.done     = state_q == wavhdr_pkg::CsDone;
  assign rsp_o.quotient = quot_q;

endmodule

// ===== hw/rtl/wavhdr_parse.sv =====
// wavhdr_parse: byte-serial chunk walker. Shifts header bytes in one per item,
// checks tags, skips bodies, captures fmt fields and forms the verdict.
// Depends on wavhdr_pkg; drives wavhdr_calc through calc_req_t.
module wavhdr_parse #(
  parameter int HEAD_LIMIT = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  acc_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  input  wavhdr_pkg::calc_rsp_t calc_rsp_i,
  output wavhdr_pkg::calc_req_t calc_req_o,
  output wavhdr_pkg::result_t   res_o,
  output logic                  busy_o
);

  localparam int PosW = $clog2(HEAD_LIMIT + 1);
  localparam int OffW = wavhdr_pkg::OffW;

  wavhdr_pkg::phase_e phase_q, phase_d, phase_nx;

  logic [PosW-1:0] pos_q;
  logic [63:0]     hdr_q, hdr_d;
  logic [31:0]     skip_q, skip_d;
  logic [OffW-1:0] off_q, off_d;
  logic [15:0]     chan_q, chan_d;
  logic [31:0]     rate_q, rate_d;
  logic [15:0]     bits_q, bits_d;
  logic            verdict_q, verdict_d;
  logic            last_pend_q, last_pend_d;

  logic [63:0] hdr_new;
  logic [31:0] chunk_id;
  logic [31:0] chunk_size;
  logic [31:0] skip_new;
  logic [31:0] skip_dec;
  logic        act;
  logic        hdr_full;
  logic        fields_bad;
  logic        fmt_take;
  logic        calc_ok;
  logic        clear;
  logic        start;

  assign act        = acc_i && !verdict_q && (pos_q < PosW'(HEAD_LIMIT));
  assign hdr_new    = {byte_i, hdr_q[63:8]};
  assign chunk_id   = hdr_new[31:0];
  assign chunk_size = hdr_new[63:32];
  assign skip_new   = chunk_size + {31'b0, chunk_size[0]};
  assign skip_dec   = (skip_q == '0) ? '0 : skip_q - 32'd1;
  assign hdr_full   = off_q == OffW'(wavhdr_pkg::HdrBytes - 1);
  assign fields_bad = (rate_q == '0) || rate_q[31] || (chan_q == '0) || (bits_q[15:3] == '0);
  assign fmt_take   = (chunk_id == wavhdr_pkg::TagFmt) &&
                      (chunk_size >= 32'(wavhdr_pkg::FmtMin));
  assign calc_ok    = (chunk_id == wavhdr_pkg::TagData) && !fields_bad && !chunk_size[31];

  // Next phase from this item, before the end-of-file clear
  always_comb begin
    phase_nx = phase_q;
    case (phase_q)
      wavhdr_pkg::PhTag: begin
        if (act && pos_q == PosW'(wavhdr_pkg::WaveEnd) &&
            hdr_new[63:32] == wavhdr_pkg::TagWave) begin
          phase_nx = wavhdr_pkg::PhHdr;
        end
      end
      wavhdr_pkg::PhHdr: begin
        if (act && hdr_full) begin
          if (chunk_id == wavhdr_pkg::TagData) begin
            if (calc_ok) phase_nx = wavhdr_pkg::PhCalc;
          end else if (chunk_size < wavhdr_pkg::SizeOverflow) begin
            if (fmt_take) begin
              phase_nx = wavhdr_pkg::PhFmt;
            end else if (skip_new != '0) begin
              phase_nx = wavhdr_pkg::PhSkip;
            end
          end
        end
      end
      wavhdr_pkg::PhFmt, wavhdr_pkg::PhSkip: begin
        if (act && skip_dec == '0) phase_nx = wavhdr_pkg::PhHdr;
      end
      wavhdr_pkg::PhCalc: begin
        if (calc_rsp_i.done) begin
          phase_nx = (pos_q >= PosW'(wavhdr_pkg::MinHead)) ? wavhdr_pkg::PhHdr
                                                          : wavhdr_pkg::PhWait;
        end
      end
      default: ;
    endcase
  end

  assign clear   = (acc_i && last_i && phase_nx != wavhdr_pkg::PhCalc) ||
                   (phase_q == wavhdr_pkg::PhCalc && calc_rsp_i.done && last_pend_q);
  assign phase_d = clear ? wavhdr_pkg::PhTag : phase_nx;

  // Datapath updates and the verdict
  always_comb begin
    hdr_d       = hdr_q;
    skip_d      = skip_q;
    off_d       = off_q;
    chan_d      = chan_q;
    rate_d      = rate_q;
    bits_d      = bits_q;
    verdict_d   = verdict_q;
    last_pend_d = last_pend_q;
    start       = 1'b0;
    res_o       = '0;
    if (act) begin
      case (phase_q)
        wavhdr_pkg::PhTag: begin
          hdr_d = hdr_new;
          if ((pos_q == PosW'(wavhdr_pkg::RiffEnd) && hdr_new[63:32] != wavhdr_pkg::TagRiff) ||
              (pos_q == PosW'(wavhdr_pkg::WaveEnd) && hdr_new[63:32] != wavhdr_pkg::TagWave)) begin
            res_o.valid  = 1'b1;
            res_o.status = wavhdr_pkg::StBadTag;
          end
          if (pos_q == PosW'(wavhdr_pkg::WaveEnd)) off_d = '0;
        end
        wavhdr_pkg::PhHdr: begin
          hdr_d = hdr_new;
          if (!hdr_full) begin
            off_d = off_q + 1'b1;
          end else begin
            off_d = '0;
            if (chunk_id == wavhdr_pkg::TagData) begin
              if (fields_bad) begin
                res_o.valid  = 1'b1;
                res_o.status = wavhdr_pkg::StBadFmt;
              end else if (chunk_size[31]) begin
                res_o.valid  = 1'b1;
                res_o.status = wavhdr_pkg::StNoData;
              end else begin
                start       = 1'b1;
                last_pend_d = last_i;
              end
            end else if (chunk_size >= wavhdr_pkg::SizeOverflow) begin
              res_o.valid  = 1'b1;
              res_o.status = wavhdr_pkg::StOverflow;
            end else begin
              skip_d = skip_new;
            end
          end
        end
        wavhdr_pkg::PhFmt: begin
          case (off_q)
            OffW'(wavhdr_pkg::FmtOffChan):     chan_d[7:0]   = byte_i;
            OffW'(wavhdr_pkg::FmtOffChan + 1): chan_d[15:8]  = byte_i;
            OffW'(wavhdr_pkg::FmtOffRate):     rate_d[7:0]   = byte_i;
            OffW'(wavhdr_pkg::FmtOffRate + 1): rate_d[15:8]  = byte_i;
            OffW'(wavhdr_pkg::FmtOffRate + 2): rate_d[23:16] = byte_i;
            OffW'(wavhdr_pkg::FmtOffRate + 3): rate_d[31:24] = byte_i;
            OffW'(wavhdr_pkg::FmtOffBits):     bits_d[7:0]   = byte_i;
            OffW'(wavhdr_pkg::FmtOffBits + 1): bits_d[15:8]  = byte_i;
            default: ;
          endcase
          if (off_q < OffW'(wavhdr_pkg::FmtMin)) off_d = off_q + 1'b1;
          skip_d = skip_dec;
          if (skip_dec == '0) off_d = '0;
        end
        wavhdr_pkg::PhSkip: skip_d = skip_dec;
        wavhdr_pkg::PhWait: begin
          if (pos_q >= PosW'(wavhdr_pkg::MinHead - 1)) begin
            res_o.valid    = 1'b1;
            res_o.status   = wavhdr_pkg::StOk;
            res_o.duration = calc_rsp_i.quotient;
          end
        end
        default: ;
      endcase
    end
    // Quotient ready: report now, fail if the file already ended, or hold it until the head is long enough
    if (phase_q == wavhdr_pkg::PhCalc && calc_rsp_i.done) begin
      if (pos_q >= PosW'(wavhdr_pkg::MinHead)) begin
        res_o.valid    = 1'b1;
        res_o.status   = wavhdr_pkg::StOk;
        res_o.duration = calc_rsp_i.quotient;
      end else if (last_pend_q) begin
        res_o.valid  = 1'b1;
        res_o.status = wavhdr_pkg::StBadTag;
      end
    end
    // Final byte with no verdict yet
    if (acc_i && last_i && phase_nx != wavhdr_pkg::PhCalc && !verdict_q && !res_o.valid) begin
      res_o.valid  = 1'b1;
      res_o.status = (phase_nx == wavhdr_pkg::PhTag || phase_nx == wavhdr_pkg::PhWait) ?
                     wavhdr_pkg::StBadTag : wavhdr_pkg::StNoData;
    end
    if (res_o.valid) verdict_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wavhdr_pkg::PhTag;
      pos_q       <= '0;
      skip_q      <= '0;
      off_q       <= '0;
      chan_q      <= '0;
      rate_q      <= '0;
      bits_q      <= '0;
      verdict_q   <= 1'b0;
      last_pend_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (clear) begin
        pos_q       <= '0;
        skip_q      <= '0;
        off_q       <= '0;
        chan_q      <= '0;
        rate_q      <= '0;
        bits_q      <= '0;
        verdict_q   <= 1'b0;
        last_pend_q <= 1'b0;
      end else begin
        if (acc_i && pos_q != PosW'(HEAD_LIMIT)) pos_q <= pos_q + 1'b1;
        skip_q      <= skip_d;
        off_q       <= off_d;
        chan_q      <= chan_d;
        rate_q      <= rate_d;
        bits_q      <= bits_d;
        verdict_q   <= verdict_d;
        last_pend_q <= last_pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

  assign calc_req_o.start     = start;
  assign calc_req_o.channels  = chan_q;
  assign calc_req_o.bytes_per = bits_q[15:3];
  assign calc_req_o.rate      = rate_q[30:0];
  assign calc_req_o.size      = chunk_size[30:0];
  assign busy_o               = phase_q == wavhdr_pkg::PhCalc;

endmodule
